// ----- rtl/mmtm_pkg.sv -----
// Package for the trimmed-mean averager: shared constants and the
// command and status structs between controller and datapath.
// Depends on nothing; used by every module of the block.
`default_nettype none

package mmtm_pkg;

    // Width and reset value of the batch size register.
    localparam int SAMPLE_COUNT_W     = 7;
    localparam int SAMPLE_COUNT_RESET = 20;

    // Default parameter values for the top level.
    localparam int DEF_MAX_SAMPLES = 64;
    localparam int DEF_SAMPLE_BITS = 10;

    // Fraction bits of the result and the batch size from which the
    // least and greatest samples are dropped.
    localparam int FRAC_BITS      = 8;
    localparam int TRIM_THRESHOLD = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take the sample on the input into the batch
        logic load;     // start the divide and clear the batch
        logic step;     // one quotient bit
        logic emit;     // write the quotient into the output register
    } mmtm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;       // the sample on the input closes the batch
        logic div_last;   // the current step yields the final quotient bit
        logic out_busy;   // the output register holds an item not yet taken
    } mmtm_status_t;

endpackage

`default_nettype wire

// ----- rtl/mmtm_ctrl.sv -----
// Controller of the trimmed-mean averager: sequences gathering,
// divide and output of one batch.
// Depends on mmtm_pkg.
`default_nettype none

module mmtm_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire mmtm_pkg::mmtm_status_t status,
    output mmtm_pkg::mmtm_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.last)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    // The input is open only in the gathering state.
    assign in_ready = ready_reg;

endmodule

`default_nettype wire

// ----- rtl/mmtm_datapath.sv -----
// Datapath of the trimmed-mean averager: batch sum, least and greatest
// sample, a bit-serial restoring divider and the output register.
// Depends on mmtm_pkg.
`default_nettype none

module mmtm_datapath #(
    parameter int MAX_SAMPLES = mmtm_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = mmtm_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                            clk,
    input  wire                                            rst_n,
    input  wire                                            cfg_we,
    input  wire  [mmtm_pkg::SAMPLE_COUNT_W-1:0]            cfg_wdata,
    input  wire  [SAMPLE_BITS-1:0]                         sample,
    input  wire  mmtm_pkg::mmtm_cmd_t                      cmd,
    output mmtm_pkg::mmtm_status_t                         status,
    output logic [SAMPLE_BITS+mmtm_pkg::FRAC_BITS-1:0]     average_q8,
    output logic                                           out_valid,
    input  wire                                            out_ready
);

    localparam int FB     = mmtm_pkg::FRAC_BITS;
    localparam int CFG_W  = mmtm_pkg::SAMPLE_COUNT_W;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int DVD_W  = SUM_W + FB;
    localparam int OUT_W  = SAMPLE_BITS + FB;
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [CFG_W-1:0]       sample_count_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] least_reg;
    logic [SAMPLE_BITS-1:0] greatest_reg;
    logic [CNT_W-1:0]       taken_reg;
    logic [DVD_W-1:0]       quo_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       div_reg;
    logic                   trim_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [OUT_W-1:0]       avg_reg;
    logic                   out_valid_reg;

    logic [CW-1:0]    eff_count;
    logic [CW:0]      taken_plus;
    logic             trim;
    logic [SUM_W-1:0] kept;
    logic [CNT_W:0]   trial;
    logic             fits;
    logic [CNT_W:0]   diff;

    // Batch size in force: zero acts as one, anything above the bound as the bound.
    always_comb
    begin
        if (sample_count_reg == '0)
        begin
            eff_count = CW'(1);
        end
        else if (CW'(sample_count_reg) > CW'(MAX_SAMPLES))
        begin
            eff_count = CW'(MAX_SAMPLES);
        end
        else
        begin
            eff_count = CW'(sample_count_reg);
        end
    end

    assign taken_plus = {1'b0, CW'(taken_reg)} + (CW + 1)'(1);
    assign trim       = (taken_reg >= CNT_W'(mmtm_pkg::TRIM_THRESHOLD));
    assign kept       = sum_reg - SUM_W'(least_reg) - SUM_W'(greatest_reg);

    // One restoring divide step: bring down the next dividend bit.
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    assign status.last     = (taken_plus >= {1'b0, eff_count});
    assign status.div_last = (step_reg == STEP_W'(1));
    assign status.out_busy = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= CFG_W'(mmtm_pkg::SAMPLE_COUNT_RESET);
            sum_reg          <= '0;
            least_reg        <= '0;
            greatest_reg     <= '0;
            taken_reg        <= '0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sample_count_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                sum_reg   <= sum_reg + SUM_W'(sample);
                taken_reg <= taken_reg + CNT_W'(1);
                if (taken_reg == '0 || sample < least_reg)
                begin
                    least_reg <= sample;
                end
                if (taken_reg == '0 || sample > greatest_reg)
                begin
                    greatest_reg <= sample;
                end
            end
            else if (cmd.load)
            begin
                sum_reg      <= '0;
                least_reg    <= '0;
                greatest_reg <= '0;
                taken_reg    <= '0;
            end
            if (cmd.load)
            begin
                step_reg <= STEP_W'(DVD_W);
            end
            else if (cmd.step)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            trim_reg <= trim;
            rem_reg  <= '0;
            if (trim)
            begin
                quo_reg <= {kept, FB'(0)};
                div_reg <= taken_reg - CNT_W'(2);
            end
            else
            begin
                quo_reg <= DVD_W'(sum_reg);
                div_reg <= taken_reg;
            end
        end
        else if (cmd.step)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
        if (cmd.emit)
        begin
            if (trim_reg)
            begin
                avg_reg <= quo_reg[OUT_W-1:0];
            end
            else
            begin
                avg_reg <= {quo_reg[SAMPLE_BITS-1:0], FB'(0)};
            end
        end
    end

    assign average_q8 = avg_reg;
    assign out_valid  = out_valid_reg;

`ifndef SYNTHESIS
    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= CNT_W'(MAX_SAMPLES))
        else $error("batch count beyond its bound");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg != '0 |-> least_reg <= greatest_reg)
        else $error("least sample above greatest sample");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg)
        else $error("result written over an untaken item");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0 && $past(step_reg) != '0) |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ----- rtl/min_max_trimmed_mean_top.sv -----
// Top level of the trimmed-mean averager: controller plus datapath.
// Depends on mmtm_pkg, mmtm_ctrl and mmtm_datapath.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) carries one converter
//   sample per item. After sample_count samples (zero acts as one, values
//   above MAX_SAMPLES act as MAX_SAMPLES) the block emits one average on
//   the master channel (m_tvalid, m_tready, m_tdata) and starts a new batch.
//   Batches of five or more drop one least and one greatest sample and
//   divide the rest by count minus two; smaller batches give the integer
//   mean. The result is unsigned fixed point with FRAC_BITS fraction bits.
//   sample_count is written through cfg_we and cfg_wdata while idle.
// Sequence:
//   A sample that does not close its batch leaves the input open, so such
//   items may arrive back to back. A closing sample is followed by a load
//   state, then one divide step per bit of the dividend in the bit-serial
//   divider (SAMPLE_BITS + log2(MAX_SAMPLES) + 8 bits, 24 by default), then
//   the write of the output register once that register is free: only then
//   is the input open to the next sample.
// Reset and stalls:
//   Reset clears the batch and loads sample_count with 20. When the
//   receiver stalls, samples of the next batch are still taken until it
//   closes; its result then waits, with the input held off, until the
//   output register has been read.
`default_nettype none

module min_max_trimmed_mean_top #(
    parameter int MAX_SAMPLES = mmtm_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = mmtm_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    // Batch size register.
    input  wire                                     cfg_we,
    input  wire  [mmtm_pkg::SAMPLE_COUNT_W-1:0]     cfg_wdata,
    // Sample input.
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,   // sample
    // Average output.
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    output logic [((SAMPLE_BITS+mmtm_pkg::FRAC_BITS+7)/8)*8-1:0] m_tdata  // average_q8
);

    localparam int OUT_W  = SAMPLE_BITS + mmtm_pkg::FRAC_BITS;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    mmtm_pkg::mmtm_cmd_t    cmd;
    mmtm_pkg::mmtm_status_t status;
    logic [OUT_W-1:0]       average_q8;

    // The controller only sequences; all arithmetic lives in the datapath.
    mmtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Bits of s_tdata above SAMPLE_BITS are padding and are ignored.
    mmtm_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .sample     (s_tdata[SAMPLE_BITS-1:0]),
        .cmd        (cmd),
        .status     (status),
        .average_q8 (average_q8),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    // The average sits in the low bits; the pad up to whole bytes is zero.
    assign m_tdata = OUT_TW'(average_q8);

endmodule

`default_nettype wire

// ----- bench/trimmed_mean_checker.sv -----
// Checker for the trimmed-mean averager: follows the sample, result and batch size ports,
// predicts every batch average and compares it with what the block emits.
// Depends on mmtm_pkg for the register width, reset value and arithmetic constants.
`timescale 1ns / 100ps

module trimmed_mean_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // sample
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // average_q8
    output int          errors,
    output int          outstanding
);

    localparam int CFG_W = mmtm_pkg::SAMPLE_COUNT_W;
    localparam int SMP_W = mmtm_pkg::DEF_SAMPLE_BITS;
    localparam int FB    = mmtm_pkg::FRAC_BITS;
    localparam int AVG_W = mmtm_pkg::DEF_SAMPLE_BITS + mmtm_pkg::FRAC_BITS;

    logic [CFG_W-1:0]  batch_size;
    logic [16:0]       batch_sum;
    logic [SMP_W-1:0]  batch_low;
    logic [SMP_W-1:0]  batch_high;
    logic [6:0]        batch_taken;
    logic [AVG_W-1:0]  averages_due[$];

    function automatic logic [6:0] effective_size(input logic [CFG_W-1:0] size);
        if (size == '0)
            return 7'd1;
        if (size > 7'(mmtm_pkg::DEF_MAX_SAMPLES))
            return 7'(mmtm_pkg::DEF_MAX_SAMPLES);
        return size;
    endfunction

    function automatic logic [AVG_W-1:0] trimmed_average(input logic [16:0] total,
                                                         input logic [SMP_W-1:0] low,
                                                         input logic [SMP_W-1:0] high,
                                                         input logic [6:0] n);
        logic [31:0] wide_sum;
        logic [31:0] wide_n;
        logic [31:0] quotient;
        wide_sum = {15'd0, total};
        wide_n   = {25'd0, n};
        if (n < 7'(mmtm_pkg::TRIM_THRESHOLD))
            quotient = (wide_sum / wide_n) << FB;
        else
            quotient = ((wide_sum - 32'(low) - 32'(high)) << FB) / (wide_n - 32'd2);
        return quotient[AVG_W-1:0];
    endfunction

    task automatic clear_batch();
        batch_sum   = '0;
        batch_low   = '0;
        batch_high  = '0;
        batch_taken = '0;
    endtask

    task automatic take_sample(input logic [SMP_W-1:0] smp);
        if (batch_taken == 7'd0)
        begin
            batch_low  = smp;
            batch_high = smp;
        end
        else
        begin
            if (smp < batch_low)
                batch_low = smp;
            if (smp > batch_high)
                batch_high = smp;
        end
        batch_sum   = batch_sum + 17'(smp);
        batch_taken = batch_taken + 7'd1;
        // A batch also closes when the size was lowered below the samples already taken.
        if (batch_taken >= effective_size(batch_size))
        begin
            averages_due.push_back(trimmed_average(batch_sum, batch_low, batch_high,
                                                   batch_taken));
            clear_batch();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_size = CFG_W'(mmtm_pkg::SAMPLE_COUNT_RESET);
            clear_batch();
            averages_due.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                batch_size = cfg_wdata;
            // Results are checked before the sample of this edge can queue a new one.
            if (m_tvalid && m_tready)
            begin
                if (averages_due.size() == 0)
                begin
                    $display("%0t: unexpected average, expected none, got %0d",
                             $time, m_tdata[AVG_W-1:0]);
                    errors = errors + 1;
                end
                else if (m_tdata[AVG_W-1:0] !== averages_due[0])
                begin
                    $display("%0t: average mismatch, expected %0d, got %0d",
                             $time, averages_due[0], m_tdata[AVG_W-1:0]);
                    errors = errors + 1;
                    void'(averages_due.pop_front());
                end
                else
                    void'(averages_due.pop_front());
            end
            if (s_tvalid && s_tready)
                take_sample(s_tdata[SMP_W-1:0]);
            outstanding = averages_due.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the trimmed-mean averager: clock, reset, sample and batch size stimulus,
// receiver stalls, watchdog and verdict.
// Depends on mmtm_pkg, min_max_trimmed_mean_top and trimmed_mean_checker.
`timescale 1ns / 100ps

module tb;

    localparam int CFG_W = mmtm_pkg::SAMPLE_COUNT_W;
    localparam int SMP_W = mmtm_pkg::DEF_SAMPLE_BITS;
    localparam int MAX_N = mmtm_pkg::DEF_MAX_SAMPLES;
    localparam int S_W = ((mmtm_pkg::DEF_SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_W = ((mmtm_pkg::DEF_SAMPLE_BITS + mmtm_pkg::FRAC_BITS + 7) / 8) * 8;
    // Least number of random samples sent after the directed part.
    localparam int RANDOM_ITEMS = 1650;
    // Cycles to wait after the last expected average before the batch size is touched again.
    localparam int SETTLE_CYCLES = 40;
    // Cycles without any item moving on either channel before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Percentage of cycles in which each side holds back.
    localparam int IDLE_PCT = 23;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_W-1:0]          cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_W-1:0]            s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [M_W-1:0]            m_tdata;

    // While set, neither the sender nor the receiver holds back.
    logic calm = 1'b0;

    int errors;
    int outstanding;
    int quiet_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    min_max_trimmed_mean_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    trimmed_mean_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // The receiver stalls at random, except during the calm stretch.
    always @(posedge clk)
        m_tready <= calm || (int'($urandom_range(0, 99)) >= IDLE_PCT);

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one sample, possibly after a few idle cycles, and returns just after the edge at
    // which the block took it. Valid stays high so back-to-back items are offered without a gap.
    task automatic send_sample(input logic [SMP_W-1:0] smp);
        while (!calm && (int'($urandom_range(0, 99)) < IDLE_PCT))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_W - SMP_W){1'b0}}, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stops offering samples, waits for every predicted average to come out and then lets the
    // divider run dry, so that the batch size may be written safely afterwards.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // One-cycle write of the batch size register; only called right after settle().
    task automatic write_batch_size(input logic [CFG_W-1:0] size);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random sample: half uniform, some at the rails, some clustered near a per-batch level
    // so that ties on the least and greatest value come up often.
    function automatic logic [SMP_W-1:0] pick_sample(input int level);
        int roll;
        roll = int'($urandom_range(0, 9));
        if (roll < 5)
            return SMP_W'($urandom_range(0, 1023));
        if (roll < 7)
            return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
        return SMP_W'(level) + SMP_W'($urandom_range(0, 2));
    endfunction

    initial
    begin
        logic [CFG_W-1:0] sizes_first[9];
        logic [CFG_W-1:0] size;
        int eff;
        int batch_items;
        int level;
        int sent;
        int phase;
        int roll;

        // The first random phases visit the limits of the batch size register: the smallest
        // sizes, the largest legal one, values past the bound, zero, and the reset value.
        sizes_first = '{7'd1, 7'd2, 7'd3, 7'd127, 7'd64, 7'd65, 7'd0, 7'd6, 7'd20};

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Size lowered mid-batch, starting from the reset size of 20: five samples with ties
        // at both rails close nothing; after the size drops to three, the next sample closes a
        // batch of six, and only one zero and one 1023 are dropped.
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd0);
        send_sample(10'd512);
        settle();
        write_batch_size(7'd3);
        send_sample(10'd7);
        settle();

        // A size of zero acts as one: each sample is its own average.
        write_batch_size(7'd0);
        send_sample(10'd1023);
        send_sample(10'd0);
        settle();

        // Below the trimming threshold the mean is an integer quotient with zero fraction.
        write_batch_size(7'd4);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd1022);
        settle();

        // Exactly at the threshold, with ties on both ends.
        write_batch_size(7'd5);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd300);
        settle();

        // Random part: each phase writes a batch size, sends a run of samples that usually
        // leaves a partial batch behind, and settles. Partial batches carried across size
        // changes exercise both raised and lowered sizes in the middle of a batch.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase < 9)
                size = sizes_first[phase];
            else
            begin
                roll = int'($urandom_range(0, 9));
                if (roll < 7)
                    size = CFG_W'($urandom_range(1, 12));
                else if (roll < 9)
                    size = CFG_W'($urandom_range(13, 64));
                else
                    size = CFG_W'($urandom_range(0, 127));
            end
            write_batch_size(size);
            eff = int'(size);
            if (eff == 0)
                eff = 1;
            if (eff > MAX_N)
                eff = MAX_N;
            batch_items = int'($urandom_range(10, 40)) + 2 * eff;
            level = int'($urandom_range(0, 1021));
            // A long stretch in the middle of the run goes without any idling on either side.
            calm = (sent >= 700) && (sent < 1000);
            for (int k = 0; k < batch_items; k++)
                send_sample(pick_sample(level));
            sent = sent + batch_items;
            settle();
            phase = phase + 1;
        end

        if ((errors == 0) && (outstanding == 0))
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mmtm_pkg.sv
rtl/mmtm_ctrl.sv
rtl/mmtm_datapath.sv
rtl/min_max_trimmed_mean_top.sv
bench/trimmed_mean_checker.sv
bench/tb.sv
